// ===== hdl/mnde_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnde_pkg
// Shared constants, codes and types of the MIDI note duration extractor.
// ----------------------------------------------------------------------------
package mnde_pkg;

	localparam int TRACK_BYTES = 16384;
	localparam int ADDR_W      = $clog2(TRACK_BYTES);
	localparam int CNT_W       = ADDR_W + 1;
	// Scan positions may run a few bytes past the loaded track.
	localparam int POS_W       = ADDR_W + 2;
	localparam int DUR_W       = 32;

	localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

	localparam logic       MODE_LOAD = 1'b0;
	localparam logic       MODE_REQ  = 1'b1;

	localparam logic [3:0] HI_NOTE_ON  = 4'h9;
	localparam logic [3:0] HI_NOTE_OFF = 4'h8;
	localparam logic [3:0] HI_DELTA    = 4'h0;
	localparam logic [7:0] PITCH_REST  = 8'd128;

	localparam logic [1:0] STAT_NOTE       = 2'd0;
	localparam logic [1:0] STAT_NO_MORE    = 2'd1;
	localparam logic [1:0] STAT_UNMATCHED  = 2'd2;
	localparam logic [1:0] STAT_NOT_LOADED = 2'd3;

	typedef struct packed {
		logic [7:0]       pitch;
		logic [7:0]       velocity;
		logic [DUR_W-1:0] duration;
		logic [1:0]       status;
	} mnde_res_t;

	typedef struct packed {
		logic             start;
		logic             clear;
		logic             ack;
		logic             track_ready;
		logic [CNT_W-1:0] count;
	} mnde_ctl_t;

	typedef struct packed {
		logic      idle;
		logic      done;
		mnde_res_t res;
	} mnde_sts_t;

endpackage

// ===== hdl/mnde_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnde_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module mnde_ram #(
	parameter int DEPTH  = 16384,
	parameter int ADDR_W = 14,
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/mnde_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnde_walker
// Walks the track store one byte per cycle to find and time the next note.
// ----------------------------------------------------------------------------
module mnde_walker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mnde_pkg::mnde_ctl_t        ctl,
	input  logic [7:0]                 rdata,
	output logic [mnde_pkg::POS_W-1:0] raddr,
	output mnde_pkg::mnde_sts_t        sts
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_PRE    = 9'b000000010,
		S_SKIP   = 9'b000000100,
		S_NOTE_P = 9'b000001000,
		S_NOTE_V = 9'b000010000,
		S_OFF_V  = 9'b000100000,
		S_DELTA  = 9'b001000000,
		S_EVT_ST = 9'b010000000,
		S_EVT_P  = 9'b100000000
	} walk_state_t;

	localparam int POS_W = mnde_pkg::POS_W;
	localparam int DUR_W = mnde_pkg::DUR_W;

	walk_state_t st_q, st_d;
	logic        done_q, done_d;
	logic [POS_W-1:0] rpos_q;
	logic             inr_s1;
	logic [POS_W-1:0] scan_q, scan_d;
	logic             skipped_q, skipped_d;
	logic [3:0]       prev_hi_q, prev_hi_d;
	logic [7:0]       pitch_q, pitch_d;
	logic [7:0]       vel_q, vel_d;
	logic [DUR_W-1:0] sum_q, sum_d;
	logic [DUR_W-1:0] dv_q, dv_d;
	logic             dsat_q, dsat_d;
	logic             on_q, on_d;
	mnde_pkg::mnde_res_t res_q, res_d;

	logic [POS_W-1:0] end_pos, p1, p2, p3;
	logic [7:0]       b;
	logic [3:0]       hi;
	logic [DUR_W-1:0] dcont, dval, sum_new;
	logic [DUR_W:0]   sum_wide;

	// Bytes at or past the loaded length read as zero.
	assign b       = inr_s1 ? rdata : 8'h00;
	assign hi      = b[7:4];
	assign end_pos = {1'b0, ctl.count};
	assign p1      = rpos_q + POS_W'(1);
	assign p2      = rpos_q + POS_W'(2);
	assign p3      = rpos_q + POS_W'(3);

	assign dcont    = dv_q | {{(DUR_W-7){1'b0}}, b[6:0]};
	assign dval     = dsat_q ? mnde_pkg::DUR_MAX : (dv_q | {{(DUR_W-8){1'b0}}, b});
	assign sum_wide = {1'b0, sum_q} + {1'b0, dval};
	assign sum_new  = sum_wide[DUR_W] ? mnde_pkg::DUR_MAX : sum_wide[DUR_W-1:0];

	always_comb begin
		st_d      = st_q;
		done_d    = done_q;
		raddr     = rpos_q;
		scan_d    = scan_q;
		skipped_d = skipped_q;
		prev_hi_d = prev_hi_q;
		pitch_d   = pitch_q;
		vel_d     = vel_q;
		sum_d     = sum_q;
		dv_d      = dv_q;
		dsat_d    = dsat_q;
		on_d      = on_q;
		res_d     = res_q;
		unique case (st_q)
			S_IDLE: begin
				if (done_q) begin
					if (ctl.ack) begin
						done_d = 1'b0;
					end
				end else if (ctl.start) begin
					if (!ctl.track_ready) begin
						res_d  = '{8'd0, 8'd0, '0, mnde_pkg::STAT_NOT_LOADED};
						done_d = 1'b1;
					end else if (!skipped_q) begin
						raddr = '0;
						st_d  = S_PRE;
					end else begin
						raddr = scan_q;
						st_d  = S_SKIP;
					end
				end
			end
			S_PRE: begin
				// Looks for a delta byte with high nibble zero followed by a note-on.
				if (rpos_q >= end_pos) begin
					skipped_d = 1'b1;
					raddr     = end_pos;
					st_d      = S_SKIP;
				end else if (rpos_q != '0 && prev_hi_q == mnde_pkg::HI_DELTA &&
						hi == mnde_pkg::HI_NOTE_ON) begin
					skipped_d = 1'b1;
					raddr     = rpos_q;
					st_d      = S_SKIP;
				end else begin
					prev_hi_d = hi;
					raddr     = p1;
				end
			end
			S_SKIP: begin
				if (rpos_q >= end_pos) begin
					scan_d = rpos_q;
					res_d  = '{8'd0, 8'd0, '0, mnde_pkg::STAT_NO_MORE};
					done_d = 1'b1;
					st_d   = S_IDLE;
				end else if (hi == mnde_pkg::HI_NOTE_ON) begin
					raddr = p1;
					st_d  = S_NOTE_P;
				end else if (hi == mnde_pkg::HI_NOTE_OFF) begin
					raddr = p2;
					st_d  = S_OFF_V;
				end else begin
					raddr = p1;
				end
			end
			S_NOTE_P: begin
				pitch_d = b;
				raddr   = p1;
				st_d    = S_NOTE_V;
			end
			S_NOTE_V: begin
				vel_d  = b;
				scan_d = p1;
				sum_d  = '0;
				dv_d   = '0;
				dsat_d = 1'b0;
				on_d   = 1'b1;
				raddr  = p1;
				if (p1 >= end_pos) begin
					res_d  = '{pitch_q, b, '0, mnde_pkg::STAT_UNMATCHED};
					done_d = 1'b1;
					st_d   = S_IDLE;
				end else begin
					st_d = S_DELTA;
				end
			end
			S_OFF_V: begin
				vel_d  = b;
				scan_d = p1;
				dv_d   = '0;
				dsat_d = 1'b0;
				on_d   = 1'b0;
				raddr  = p1;
				st_d   = S_DELTA;
			end
			S_DELTA: begin
				raddr = p1;
				if (b[7]) begin
					dsat_d = dsat_q | (|dcont[DUR_W-1:DUR_W-7]);
					dv_d   = dcont << 7;
				end else if (!on_q) begin
					res_d  = '{mnde_pkg::PITCH_REST, vel_q, dval, mnde_pkg::STAT_NOTE};
					done_d = 1'b1;
					st_d   = S_IDLE;
				end else begin
					sum_d = sum_new;
					if (p1 < end_pos) begin
						st_d = S_EVT_ST;
					end else begin
						res_d  = '{pitch_q, vel_q, sum_new, mnde_pkg::STAT_UNMATCHED};
						done_d = 1'b1;
						st_d   = S_IDLE;
					end
				end
			end
			S_EVT_ST: begin
				if (hi == mnde_pkg::HI_NOTE_OFF) begin
					raddr = p1;
					st_d  = S_EVT_P;
				end else begin
					// Step over a three-byte event to the next delta.
					raddr  = p3;
					dv_d   = '0;
					dsat_d = 1'b0;
					if (p3 < end_pos) begin
						st_d = S_DELTA;
					end else begin
						res_d  = '{pitch_q, vel_q, sum_q, mnde_pkg::STAT_UNMATCHED};
						done_d = 1'b1;
						st_d   = S_IDLE;
					end
				end
			end
			S_EVT_P: begin
				raddr  = p2;
				dv_d   = '0;
				dsat_d = 1'b0;
				if (b == pitch_q) begin
					res_d  = '{pitch_q, vel_q, sum_q, mnde_pkg::STAT_NOTE};
					done_d = 1'b1;
					st_d   = S_IDLE;
				end else if (p2 < end_pos) begin
					st_d = S_DELTA;
				end else begin
					res_d  = '{pitch_q, vel_q, sum_q, mnde_pkg::STAT_UNMATCHED};
					done_d = 1'b1;
					st_d   = S_IDLE;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
		if (ctl.clear) begin
			scan_d    = '0;
			skipped_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			done_q    <= 1'b0;
			scan_q    <= '0;
			skipped_q <= 1'b0;
		end else begin
			st_q      <= st_d;
			done_q    <= done_d;
			scan_q    <= scan_d;
			skipped_q <= skipped_d;
		end
	end

	always_ff @(posedge clk) begin
		rpos_q    <= raddr;
		inr_s1    <= raddr < end_pos;
		prev_hi_q <= prev_hi_d;
		pitch_q   <= pitch_d;
		vel_q     <= vel_d;
		sum_q     <= sum_d;
		dv_q      <= dv_d;
		dsat_q    <= dsat_d;
		on_q      <= on_d;
		res_q     <= res_d;
	end

	assign sts.idle = (st_q == S_IDLE) && !done_q;
	assign sts.done = done_q;
	assign sts.res  = res_q;

`ifndef ASSERT_OFF
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> sts.idle)
		else $error("request started while the walker was busy");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !ctl.ack) |=> (done_q && $stable(res_q)))
		else $error("pending result changed before it was taken");

	a_not_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.start && !ctl.track_ready) |=>
		(done_q && res_q.status == mnde_pkg::STAT_NOT_LOADED))
		else $error("request on an incomplete track did not report not loaded");

	a_walk_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> (!done_q && !ctl.clear))
		else $error("walk overlapped a pending result or a track reload");
`endif

endmodule

// ===== hdl/midi_note_duration_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_note_duration_extractor
// Loads a MIDI track chunk and returns its notes with their durations.
// ----------------------------------------------------------------------------
// Input stream: s_tuser selects a load (0) or a note request (1); a load
// writes s_tdata into the track store, and s_tlast marks the final byte.
// The first load after a complete track starts a new one.
// Output stream: one transfer for every request, none for a load.
// A request walks the track store one byte per cycle through the single
// read port of the memory, whose read is registered. The walk covers the
// preamble on the first request of a track, then skipped bytes, note
// bytes and the delta and event bytes up to the matching note-off. A
// request before the track is complete answers not loaded without a walk.
// A finished result moves to the output register in the cycle after the
// walk ends when that register is free, and s_tready rises right after, so
// the next item is taken while the receiver stalls. A second result waits
// inside the walker until m_tready frees the output register, and no new
// item is taken in the meantime.
// Reset clears the byte count, the scan position and the ready, done, skip and valid flags; the track
// memory itself is not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
module midi_note_duration_extractor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] mode
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [7:0] pitch, [15:8] velocity, [47:16] duration
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int ADDR_W = mnde_pkg::ADDR_W;
	localparam int CNT_W  = mnde_pkg::CNT_W;

	logic                       in_xfer, load, req;
	logic [CNT_W-1:0]           count_q, base;
	logic                       ready_q;
	logic                       we;
	logic [mnde_pkg::POS_W-1:0] raddr;
	logic [7:0]                 rdata;
	logic                       take;
	mnde_pkg::mnde_ctl_t        ctl;
	mnde_pkg::mnde_sts_t        sts;
	mnde_pkg::mnde_res_t        out_q;
	logic                       m_tvalid_q;

	assign in_xfer = s_tvalid && s_tready;
	assign load    = in_xfer && (s_tuser == mnde_pkg::MODE_LOAD);
	assign req     = in_xfer && (s_tuser == mnde_pkg::MODE_REQ);

	// A load on a complete track restarts the store from address zero.
	assign base = ready_q ? '0 : count_q;
	assign we   = load && (base < CNT_W'(mnde_pkg::TRACK_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ready_q <= 1'b0;
		end else if (load) begin
			count_q <= we ? base + CNT_W'(1) : base;
			ready_q <= s_tlast;
		end
	end

	mnde_ram #(
		.DEPTH (mnde_pkg::TRACK_BYTES),
		.ADDR_W(ADDR_W),
		.DATA_W(8)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(base[ADDR_W-1:0]),
		.wdata(s_tdata),
		.raddr(raddr[ADDR_W-1:0]),
		.rdata(rdata)
	);

	assign take            = sts.done && (!m_tvalid_q || m_tready);
	assign ctl.start       = req;
	assign ctl.clear       = load && ready_q;
	assign ctl.ack         = take;
	assign ctl.track_ready = ready_q;
	assign ctl.count       = count_q;

	mnde_walker u_walker (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.rdata (rdata),
		.raddr (raddr),
		.sts   (sts)
	);

	assign s_tready = sts.idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= sts.res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_q.duration, out_q.velocity, out_q.pitch};
	assign m_tuser  = out_q.status;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MIDI note duration extractor.
// ----------------------------------------------------------------------------
// A short table of loads and note requests covers the corner cases first.
// These are a request before any track, saturating deltas, a silence entry,
// an unmatched note-on, a missing preamble and a request on a half-loaded
// track. Then comes a long stream of random tracks, mostly well formed,
// with some noise and damaged ones.
// Every request is predicted by a behavioral copy of the extractor, and each
// output transfer is checked against the oldest predicted note. Both stream
// sides see random idle bursts, except in the final stretch of the run.
// ----------------------------------------------------------------------------
module tb_top;

	localparam logic [7:0] VLQ_MORE = 8'h80;
	localparam logic [7:0] VLQ_MASK = 8'h7f;
	localparam int         RAND_ITEMS = 925;

	typedef struct {
		logic      mode;
		logic [7:0] data;
		logic      last;
		bit        typed;
		mnde_pkg::mnde_res_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;

	// Behavioral copy of the extractor state.
	logic [7:0]  trk_mem [mnde_pkg::TRACK_BYTES];
	int unsigned trk_len;
	int unsigned scan_pos;
	bit          trk_done;
	bit          lead_found;

	mnde_pkg::mnde_res_t note_q [$];
	stim_row_t   dir_tab [$];
	logic [7:0]  trk_src [$];
	int          n_items;
	int          n_bad;
	bit          src_gaps;
	bit          calm;

	midi_note_duration_extractor uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic logic [7:0] trk_rd(input int unsigned idx);
		if (idx < trk_len && idx < mnde_pkg::TRACK_BYTES)
			return trk_mem[idx];
		return 8'd0;
	endfunction

	function automatic logic [3:0] trk_hi(input int unsigned idx);
		logic [7:0] b;
		b = trk_rd(idx);
		return b[7:4];
	endfunction

	// Reads one variable-length delta and moves p past it.
	function automatic logic [31:0] delta_at(inout int unsigned p);
		logic [31:0] acc;
		logic [7:0]  b;
		bit          ovf;
		acc = '0;
		ovf = 1'b0;
		b = trk_rd(p);
		while ((b & VLQ_MORE) != 0) begin
			acc = acc | {24'd0, b & VLQ_MASK};
			if (acc > (mnde_pkg::DUR_MAX >> 7))
				ovf = 1'b1;
			acc = acc << 7;
			p++;
			b = trk_rd(p);
		end
		acc = acc | {24'd0, b};
		p++;
		return ovf ? mnde_pkg::DUR_MAX : acc;
	endfunction

	function automatic logic [31:0] tick_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? mnde_pkg::DUR_MAX : s[31:0];
	endfunction

	// Returns 1 when the item produces a note result, which is placed in res.
	function automatic bit predict_note(input logic mode, input logic [7:0] data,
			input logic last, output mnde_pkg::mnde_res_t res);
		int unsigned stop, pos, k, i;
		logic [7:0]  pit, vel;
		logic [31:0] sum;
		logic [1:0]  st;
		res = '0;
		if (mode == mnde_pkg::MODE_LOAD) begin
			if (trk_done) begin
				trk_len = 0;
				scan_pos = 0;
				trk_done = 1'b0;
				lead_found = 1'b0;
			end
			if (trk_len < mnde_pkg::TRACK_BYTES) begin
				trk_mem[trk_len] = data;
				trk_len++;
			end
			if (last)
				trk_done = 1'b1;
			return 1'b0;
		end
		if (!trk_done) begin
			res.status = mnde_pkg::STAT_NOT_LOADED;
			return 1'b1;
		end
		stop = trk_len;
		if (!lead_found) begin
			i = 0;
			while (i + 1 < stop && !(trk_hi(i) == mnde_pkg::HI_DELTA &&
					trk_hi(i + 1) == mnde_pkg::HI_NOTE_ON))
				i++;
			scan_pos = (i + 1 < stop) ? i : stop;
			lead_found = 1'b1;
		end
		pos = scan_pos;
		while (pos < stop && trk_hi(pos) != mnde_pkg::HI_NOTE_ON &&
				trk_hi(pos) != mnde_pkg::HI_NOTE_OFF)
			pos++;
		if (pos >= stop) begin
			scan_pos = pos;
			res.status = mnde_pkg::STAT_NO_MORE;
			return 1'b1;
		end
		if (trk_hi(pos) == mnde_pkg::HI_NOTE_ON) begin
			pit = trk_rd(pos + 1);
			vel = trk_rd(pos + 2);
			sum = '0;
			st = mnde_pkg::STAT_UNMATCHED;
			pos += 3;
			k = pos;
			while (k < stop && st != mnde_pkg::STAT_NOTE) begin
				sum = tick_add(sum, delta_at(k));
				if (k < stop && trk_hi(k) == mnde_pkg::HI_NOTE_OFF && trk_rd(k + 1) == pit)
					st = mnde_pkg::STAT_NOTE;
				else
					k += 3;
			end
			scan_pos = pos;
			res.pitch = pit;
			res.velocity = vel;
			res.duration = sum;
			res.status = st;
		end else begin
			vel = trk_rd(pos + 2);
			pos += 3;
			k = pos;
			scan_pos = pos;
			res.pitch = mnde_pkg::PITCH_REST;
			res.velocity = vel;
			res.duration = delta_at(k);
			res.status = mnde_pkg::STAT_NOTE;
		end
		return 1'b1;
	endfunction

	function automatic void ld(input logic [7:0] data, input logic last);
		stim_row_t r;
		r.mode = mnde_pkg::MODE_LOAD;
		r.data = data;
		r.last = last;
		r.typed = 1'b0;
		r.want = '0;
		dir_tab.push_back(r);
	endfunction

	function automatic void rq(input bit typed, input mnde_pkg::mnde_res_t want);
		stim_row_t r;
		r.mode = mnde_pkg::MODE_REQ;
		r.data = 8'($urandom_range(0, 255));
		r.last = 1'($urandom_range(0, 1));
		r.typed = typed;
		r.want = want;
		dir_tab.push_back(r);
	endfunction

	function automatic void push_vlq(input int unsigned v);
		logic [7:0] grp [$];
		grp.push_front(8'(v) & VLQ_MASK);
		v = v >> 7;
		while (v != 0) begin
			grp.push_front(VLQ_MORE | (8'(v) & VLQ_MASK));
			v = v >> 7;
		end
		foreach (grp[i])
			trk_src.push_back(grp[i]);
	endfunction

	function automatic void push_delta();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			// Long enough to overflow 32 bits most of the time.
			repeat ($urandom_range(4, 6))
				trk_src.push_back(VLQ_MORE | 8'($urandom_range(1, 127)));
			trk_src.push_back(8'($urandom_range(0, 127)));
		end else if (r < 6) begin
			push_vlq($urandom_range(128, 32'h0fff_ffff));
		end else begin
			trk_src.push_back(8'($urandom_range(0, 127)));
		end
	endfunction

	function automatic void push_event(input logic [3:0] kind, input logic [7:0] pit);
		trk_src.push_back({kind, 4'($urandom_range(0, 15))});
		trk_src.push_back(pit);
		if ($urandom_range(0, 7) == 0)
			trk_src.push_back(8'($urandom_range(0, 255)));
		else
			trk_src.push_back(8'($urandom_range(0, 127)));
	endfunction

	// Builds one random track in trk_src and returns its number of events, or four for a track of random noise bytes.
	function automatic int build_track();
		logic [7:0] pool [4];
		int         n_ev, r, pos;
		trk_src.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 24))
				trk_src.push_back(8'($urandom_range(0, 255)));
			return 4;
		end
		foreach (pool[i])
			pool[i] = (i == 0 && $urandom_range(0, 3) == 0) ?
				8'($urandom_range(0, 1) * 127) : 8'($urandom_range(0, 127));
		repeat ($urandom_range(0, 3))
			trk_src.push_back(8'($urandom_range(0, 255)));
		trk_src.push_back(8'($urandom_range(0, 15)));
		push_event(mnde_pkg::HI_NOTE_ON, pool[$urandom_range(0, 3)]);
		n_ev = $urandom_range(2, 10);
		for (int e = 0; e < n_ev; e++) begin
			push_delta();
			r = $urandom_range(0, 9);
			if (r < 4)
				push_event(mnde_pkg::HI_NOTE_ON, pool[$urandom_range(0, 3)]);
			else if (r < 7)
				push_event(mnde_pkg::HI_NOTE_OFF, pool[$urandom_range(0, 3)]);
			else
				push_event(4'($urandom_range(10, 14)), 8'($urandom_range(0, 127)));
		end
		// Some tracks get a damaged byte or lose one.
		if ($urandom_range(0, 5) == 0) begin
			pos = $urandom_range(0, trk_src.size() - 1);
			trk_src[pos] = 8'($urandom_range(0, 255));
		end
		if ($urandom_range(0, 11) == 0)
			trk_src.delete($urandom_range(0, trk_src.size() - 1));
		return n_ev + 1;
	endfunction

	task automatic send(input logic mode, input logic [7:0] data, input logic last,
			input bit typed, input mnde_pkg::mnde_res_t want);
		mnde_pkg::mnde_res_t res;
		if (src_gaps && !calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= data;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		if (predict_note(mode, data, last, res))
			note_q.push_back(typed ? want : res);
		n_items++;
		@(negedge clk);
	endtask

	task automatic send_req();
		send(mnde_pkg::MODE_REQ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			1'b0, '0);
	endtask

	// Holds the input side off until every predicted note has been seen.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (note_q.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk) begin : note_check
		mnde_pkg::mnde_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (note_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected transfer: pitch %0d vel %0d dur %0d status %0d",
						m_tdata[7:0], m_tdata[15:8], m_tdata[47:16], m_tuser);
			end else begin
				want = note_q.pop_front();
				if (m_tdata[7:0] !== want.pitch || m_tdata[15:8] !== want.velocity ||
						m_tdata[47:16] !== want.duration || m_tuser !== want.status) begin
					n_bad++;
					if (n_bad <= 10)
						$display({"note mismatch: expected pitch %0d vel %0d dur %0d ",
							"status %0d, got pitch %0d vel %0d dur %0d status %0d"},
							want.pitch, want.velocity, want.duration, want.status,
							m_tdata[7:0], m_tdata[15:8], m_tdata[47:16], m_tuser);
				end
			end
		end
	end

	// Output side back-pressure in short random bursts.
	initial begin
		m_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#20_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		int n_ev, base;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		s_tuser = mnde_pkg::MODE_LOAD;
		s_tlast = 1'b0;
		trk_len = 0;
		scan_pos = 0;
		trk_done = 1'b0;
		lead_found = 1'b0;
		n_items = 0;
		n_bad = 0;
		src_gaps = 1'b1;
		calm = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed rows.
		rq(1'b1, {8'd0, 8'd0, 32'd0, mnde_pkg::STAT_NOT_LOADED});
		ld(8'hff, 1'b0);
		ld(8'h00, 1'b0);
		ld(8'h9f, 1'b0);
		ld(8'h7f, 1'b0);
		ld(8'hff, 1'b0);
		ld(8'hff, 1'b0);
		ld(8'hff, 1'b0);
		ld(8'hff, 1'b0);
		ld(8'hff, 1'b0);
		ld(8'h7f, 1'b0);
		ld(8'h8f, 1'b0);
		ld(8'h7f, 1'b0);
		ld(8'h00, 1'b1);
		rq(1'b1, {8'h7f, 8'hff, mnde_pkg::DUR_MAX, mnde_pkg::STAT_NOTE});
		rq(1'b0, '0);                                   // silence after the note-off
		rq(1'b1, {8'd0, 8'd0, 32'd0, mnde_pkg::STAT_NO_MORE});
		ld(8'h00, 1'b0);
		rq(1'b1, {8'd0, 8'd0, 32'd0, mnde_pkg::STAT_NOT_LOADED});
		ld(8'h90, 1'b0);
		ld(8'h00, 1'b0);
		ld(8'h00, 1'b1);
		rq(1'b1, {8'd0, 8'd0, 32'd0, mnde_pkg::STAT_UNMATCHED});
		ld(8'h90, 1'b1);
		rq(1'b1, {8'd0, 8'd0, 32'd0, mnde_pkg::STAT_NO_MORE}); // no preamble end found
		foreach (dir_tab[i])
			send(dir_tab[i].mode, dir_tab[i].data, dir_tab[i].last,
				dir_tab[i].typed, dir_tab[i].want);
		drain();

		// Random tracks, each followed by a few requests.
		base = n_items;
		while (n_items - base < RAND_ITEMS) begin
			if (n_items - base >= RAND_ITEMS - 100)
				calm = 1'b1;
			src_gaps = ($urandom_range(0, 2) != 0);
			if ($urandom_range(0, 9) == 0)
				drain();
			n_ev = build_track();
			foreach (trk_src[i]) begin
				if ($urandom_range(0, 39) == 0)
					send_req();
				send(mnde_pkg::MODE_LOAD, trk_src[i], i == trk_src.size() - 1, 1'b0, '0);
			end
			repeat ($urandom_range(0, n_ev + 2))
				send_req();
		end

		drain();
		repeat (40) @(posedge clk);
		if (n_bad == 0 && note_q.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/mnde_pkg.sv
hdl/mnde_ram.sv
hdl/mnde_walker.sv
hdl/midi_note_duration_extractor.sv
sim/tb_top.sv
